// File: hw/rtl/sdes_pkg.sv
// ----------------------------------------------------------------------------
// sdes_pkg
// Shared types, constants and permutation/S-box functions for the S-DES unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdes_pkg;

    localparam int DATA_W     = 8;
    localparam int KEY_W      = 10;
    localparam int RKEY_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_A  = 2'd0,
        CFG_KEY_B  = 2'd1,
        CFG_DOUBLE = 2'd2
    } cfg_idx_t;

    // action codes
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef struct packed {
        logic [RKEY_W-1:0] k1;
        logic [RKEY_W-1:0] k2;
    } round_keys_t;

    // S-boxes flattened as row*4 + col
    localparam logic [1:0] SBOX0 [16] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd3, 2'd2
    };
    localparam logic [1:0] SBOX1 [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3
    };

    // Table positions count from the msb (position 1), hence bit [n-p].
    function automatic logic [9:0] p10(input logic [9:0] k);
        return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
    endfunction

    function automatic logic [7:0] p8(input logic [9:0] u);
        return {u[4], u[7], u[3], u[6], u[2], u[5], u[0], u[1]};
    endfunction

    function automatic logic [7:0] ip(input logic [7:0] x);
        return {x[6], x[2], x[5], x[7], x[4], x[0], x[3], x[1]};
    endfunction

    function automatic logic [7:0] ip_inv(input logic [7:0] x);
        return {x[4], x[7], x[5], x[3], x[1], x[6], x[0], x[2]};
    endfunction

    function automatic logic [7:0] expand(input logic [3:0] r);
        return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
    endfunction

    function automatic logic [3:0] p4(input logic [3:0] s);
        return {s[2], s[0], s[1], s[3]};
    endfunction

    // row from outer bits, column from inner bits
    function automatic logic [3:0] sbox_idx(input logic [3:0] nib);
        return {nib[3], nib[0], nib[2], nib[1]};
    endfunction

    function automatic logic [3:0] feistel(input logic [3:0] r, input logic [RKEY_W-1:0] k);
        logic [7:0] e;
        logic [3:0] s;
        e = expand(r) ^ k;
        s = {SBOX0[sbox_idx(e[7:4])], SBOX1[sbox_idx(e[3:0])]};
        return p4(s);
    endfunction

    // two rounds with swap in between; ka first, kb second
    function automatic logic [7:0] cipher_block(input logic [7:0] x,
                                                input logic [RKEY_W-1:0] ka,
                                                input logic [RKEY_W-1:0] kb);
        logic [7:0] t;
        logic [3:0] l;
        logic [3:0] r;
        t = ip(x);
        l = t[7:4] ^ feistel(t[3:0], ka);
        r = l;
        l = t[3:0] ^ feistel(r, kb);
        return ip_inv({l, r});
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/simplified_des_cipher_unit.sv
// ----------------------------------------------------------------------------
// simplified_des_cipher_unit
// Simplified DES encrypt/decrypt of 8-bit blocks, single or double cipher.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready: s_tdata[7:0] is the block and
//   s_tuser the action (0 encrypt, 1 decrypt). Each input beat yields exactly
//   one output beat on m_tvalid/m_tready with the result block in m_tdata.
//   Keys and the double-cipher enable are written through cfg_we/cfg_index/
//   cfg_wdata while no beat is in flight; index 3 is ignored.
//   The input register loads at the accepting edge and the result register
//   loads from it when the result stage can accept, which raises m_tvalid.
//   Throughput is one beat per cycle while m_tready does not stall; the full
//   cipher (both passes in double mode) is done by the combinational logic
//   between the two registers.
//   When m_tready is low a valid result holds in the result register, the
//   input register still fills, and s_tready drops once both stages are occupied.
//   Reset (aresetn low, synchronous) empties both stages and clears the
//   keys and double mode to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module simplified_des_cipher_unit
    import sdes_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DATA_W-1:0]     s_tdata,   // [7:0] data_in
    input  wire logic                  s_tuser,   // [0] action
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [DATA_W-1:0]          m_tdata    // [7:0] data_out
);

    // configuration registers
    logic [KEY_W-1:0] key_a_reg;
    logic [KEY_W-1:0] key_b_reg;
    logic             double_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_a_reg  <= '0;
            key_b_reg  <= '0;
            double_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_KEY_A:  key_a_reg  <= cfg_wdata[KEY_W-1:0];
                CFG_KEY_B:  key_b_reg  <= cfg_wdata[KEY_W-1:0];
                CFG_DOUBLE: double_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // round keys
    round_keys_t rk_a;
    round_keys_t rk_b;

    sdes_key_sched u_key_a (
        .master_key (key_a_reg),
        .round_keys (rk_a)
    );

    sdes_key_sched u_key_b (
        .master_key (key_b_reg),
        .round_keys (rk_b)
    );

    // pipeline handshake
    logic              in_valid_reg;
    logic              in_action_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_ready;
    logic              in_ready;

    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_data_reg   <= s_tdata;
        end
    end

    // cipher datapath: first pass, then optional second pass
    round_keys_t       key1_sel;
    round_keys_t       key2_sel;
    logic              decrypt;
    logic [DATA_W-1:0] pass1;
    logic [DATA_W-1:0] pass2;
    logic [DATA_W-1:0] out_data_next;

    always_comb begin
        decrypt  = (in_action_reg == ACT_DECRYPT);
        // double decrypt runs key B first, then key A
        key1_sel = (double_reg && decrypt) ? rk_b : rk_a;
        key2_sel = decrypt ? rk_a : rk_b;
        pass1 = decrypt ? cipher_block(in_data_reg, key1_sel.k2, key1_sel.k1)
                        : cipher_block(in_data_reg, key1_sel.k1, key1_sel.k2);
        pass2 = decrypt ? cipher_block(pass1, key2_sel.k2, key2_sel.k1)
                        : cipher_block(pass1, key2_sel.k1, key2_sel.k2);
        out_data_next = double_reg ? pass2 : pass1;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sdes_key_sched.sv
// ----------------------------------------------------------------------------
// sdes_key_sched
// Derives the two round keys from one 10-bit master key (P10, rotates, P8).
// ----------------------------------------------------------------------------
`default_nettype none

module sdes_key_sched
    import sdes_pkg::*;
(
    input  wire logic [KEY_W-1:0] master_key,
    output round_keys_t           round_keys
);

    logic [9:0] t;
    logic [4:0] lh1, rh1, lh3, rh3;

    always_comb begin
        t = p10(master_key);
        // rotate left by 1 for round key one
        lh1 = {t[8:5], t[9]};
        rh1 = {t[3:0], t[4]};
        // further rotate by 2 for round key two
        lh3 = {lh1[2:0], lh1[4:3]};
        rh3 = {rh1[2:0], rh1[4:3]};
        round_keys.k1 = p8({lh1, rh1});
        round_keys.k2 = p8({lh3, rh3});
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for simplified_des_cipher_unit. A queue-fed driver sends
// blocks with random gaps; a monitor predicts each result with an independent
// S-DES model (single and double cipher), then checks every output beat in
// order. Keys and double mode are changed between drained phases.
// ----------------------------------------------------------------------------

module testbench;
    import sdes_pkg::*;

    localparam int          TIMEOUT_NS   = 2_000_000;
    localparam int          IDLE_PCT     = 12;
    localparam int          PHASES       = 9;
    localparam int          PHASE_BLOCKS = 200;
    // index beyond the last register, writes to it are dropped
    localparam logic [1:0]  CFG_IDX_NONE = 2'd3;

    // S-DES tables, positions count from the msb (position 1)
    localparam int P10_POS [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
    localparam int P8_POS  [8]  = '{6, 3, 7, 4, 8, 5, 10, 9};
    localparam int IP_POS  [8]  = '{2, 6, 3, 1, 4, 8, 5, 7};
    localparam int IPI_POS [8]  = '{4, 1, 3, 5, 7, 2, 8, 6};
    localparam int EP_POS  [8]  = '{4, 1, 2, 3, 2, 3, 4, 1};
    localparam int P4_POS  [4]  = '{2, 4, 3, 1};
    localparam logic [1:0] SBOX_LEFT [4][4] = '{
        '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd3, 2'd1, 2'd3, 2'd2}};
    localparam logic [1:0] SBOX_RIGHT [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd0, 2'd3}};

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] data_in;
    } cipher_req_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;

    // bench state
    cipher_req_t       pending_blocks [$];
    logic [DATA_W-1:0] pending_results [$];
    int                blocks_in_flight = 0;
    int                err_count = 0;
    int                hold_left = 0;
    bit                no_gaps = 1'b0;
    bit                in_taken = 1'b0;

    // mirrored configuration
    logic [KEY_W-1:0]  key_a_q = '0;
    logic [KEY_W-1:0]  key_b_q = '0;
    logic              double_q = 1'b0;

    simplified_des_cipher_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ---------------- prediction ----------------
    function automatic logic [9:0] perm10(input logic [9:0] k);
        logic [9:0] r;
        for (int i = 0; i < 10; i++) r[9-i] = k[10-P10_POS[i]];
        return r;
    endfunction

    function automatic logic [7:0] perm8(input logic [9:0] u);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7-i] = u[10-P8_POS[i]];
        return r;
    endfunction

    function automatic logic [7:0] init_perm(input logic [7:0] x);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7-i] = x[8-IP_POS[i]];
        return r;
    endfunction

    function automatic logic [7:0] final_perm(input logic [7:0] x);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[7-i] = x[8-IPI_POS[i]];
        return r;
    endfunction

    function automatic logic [4:0] rotl5(input logic [4:0] h, input int s);
        logic [9:0] w;
        w = {h, h} >> (5 - s);
        return w[4:0];
    endfunction

    // {k1, k2}
    function automatic logic [15:0] round_keys(input logic [9:0] key);
        logic [9:0] t;
        logic [4:0] lh;
        logic [4:0] rh;
        logic [7:0] k1;
        t  = perm10(key);
        lh = rotl5(t[9:5], 1);
        rh = rotl5(t[4:0], 1);
        k1 = perm8({lh, rh});
        lh = rotl5(lh, 2);
        rh = rotl5(rh, 2);
        return {k1, perm8({lh, rh})};
    endfunction

    function automatic logic [3:0] round_mix(input logic [3:0] r, input logic [7:0] k);
        logic [7:0] e;
        logic [3:0] s;
        logic [3:0] p;
        for (int i = 0; i < 8; i++) e[7-i] = r[4-EP_POS[i]];
        e = e ^ k;
        s = {SBOX_LEFT[{e[7], e[4]}][{e[6], e[5]}], SBOX_RIGHT[{e[3], e[0]}][{e[2], e[1]}]};
        for (int i = 0; i < 4; i++) p[3-i] = s[4-P4_POS[i]];
        return p;
    endfunction

    function automatic logic [7:0] two_rounds(input logic [7:0] x, input logic [7:0] ka,
                                              input logic [7:0] kb);
        logic [7:0] t;
        logic [3:0] lft;
        logic [3:0] fin;
        t   = init_perm(x);
        lft = t[7:4] ^ round_mix(t[3:0], ka);
        // halves swap, second round uses the new right half
        fin = t[3:0] ^ round_mix(lft, kb);
        return final_perm({fin, lft});
    endfunction

    function automatic logic [7:0] keyed_pass(input logic [7:0] x, input logic [9:0] key,
                                              input bit dec);
        logic [15:0] rk;
        rk = round_keys(key);
        return dec ? two_rounds(x, rk[7:0], rk[15:8]) : two_rounds(x, rk[15:8], rk[7:0]);
    endfunction

    function automatic logic [7:0] cipher_result(input logic action, input logic [7:0] x);
        bit dec;
        dec = (action == ACT_DECRYPT);
        if (!double_q) return keyed_pass(x, key_a_q, dec);
        if (dec) return keyed_pass(keyed_pass(x, key_b_q, 1'b1), key_a_q, 1'b1);
        return keyed_pass(keyed_pass(x, key_a_q, 1'b0), key_b_q, 1'b0);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        err_count++;
        $display("[%0t] MISMATCH %s: got %02h want %02h", $time, what, got, want);
    endtask

    // ---------------- input driver ----------------
    always @(negedge aclk) begin
        cipher_req_t req;
        if (!s_tvalid || in_taken) begin
            if (pending_blocks.size() != 0 &&
                (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
                req = pending_blocks.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= req.action;
                s_tdata  <= req.data_in;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result receiver ----------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------- monitor: config mirror, prediction, check ----------------
    always @(posedge aclk) begin
        logic [7:0] want;
        if (!aresetn) begin
            key_a_q  = '0;
            key_b_q  = '0;
            double_q = 1'b0;
            in_taken = 1'b0;
        end else begin
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                pending_results = {pending_results, cipher_result(s_tuser, s_tdata)};
                blocks_in_flight = blocks_in_flight - 1;
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, 8'h00);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want) report_mismatch("data_out", m_tdata, want);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_KEY_A:  key_a_q  = cfg_wdata[KEY_W-1:0];
                    CFG_KEY_B:  key_b_q  = cfg_wdata[KEY_W-1:0];
                    CFG_DOUBLE: double_q = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic queue_block(input logic action, input logic [7:0] data);
        cipher_req_t req;
        req.action  = action;
        req.data_in = data;
        pending_blocks = {pending_blocks, req};
        blocks_in_flight = blocks_in_flight + 1;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_drain();
        while (blocks_in_flight != 0 || pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        logic [7:0] plain;
        logic [7:0] edge_vals [6];
        int         count;
        edge_vals = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // settings for this phase, block is drained
            case (ph)
                0: ; // reset values
                1: begin
                    write_reg(CFG_KEY_A, 10'h3FF);
                    write_reg(CFG_KEY_B, 10'h000);
                end
                2: begin
                    write_reg(CFG_KEY_A, 10'($urandom_range(1023)));
                    write_reg(CFG_KEY_B, 10'($urandom_range(1023)));
                    write_reg(CFG_DOUBLE, 10'h001);
                end
                3: begin
                    write_reg(CFG_KEY_A, 10'h000);
                    write_reg(CFG_KEY_B, 10'h3FF);
                end
                4: begin
                    // dropped write, then double mode cleared by masking
                    write_reg(CFG_IDX_NONE, 10'h3FF);
                    write_reg(CFG_DOUBLE, 10'h3FE);
                    write_reg(CFG_KEY_A, 10'($urandom_range(1023)));
                end
                default: begin
                    write_reg(CFG_KEY_A, 10'($urandom_range(1023)));
                    write_reg(CFG_KEY_B, 10'($urandom_range(1023)));
                    write_reg(CFG_DOUBLE, 10'($urandom_range(1023)));
                end
            endcase

            // extremes of data with both actions
            if (ph < 2) begin
                foreach (edge_vals[i]) begin
                    queue_block(ACT_ENCRYPT, edge_vals[i]);
                    queue_block(ACT_DECRYPT, edge_vals[i]);
                end
            end

            // random blocks, many as encrypt/decrypt round trips
            count = 0;
            while (count < PHASE_BLOCKS) begin
                plain = 8'($urandom_range(255));
                if ($urandom_range(99) < 40) begin
                    queue_block(ACT_ENCRYPT, plain);
                    queue_block(ACT_DECRYPT, cipher_result(ACT_ENCRYPT, plain));
                    count += 2;
                end else begin
                    queue_block(1'($urandom_range(1)), plain);
                    count++;
                end
            end

            // long run with no gaps on either side
            if (ph == 6) begin
                @(posedge aclk);
                no_gaps = 1'b1;
            end
            // receiver back-pressure while the sender keeps offering
            if (ph == 3 || ph == 7) begin
                repeat (10) @(posedge aclk);
                hold_left = 80;
            end

            wait_drain();
            @(posedge aclk);
            no_gaps = 1'b0;
        end

        if (pending_results.size() != 0) report_mismatch("missing beat", 8'h00, 8'h00);
        if (err_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // ---------------- run limit ----------------
    initial begin
        #(TIMEOUT_NS);
        $display("testbench failed");
        $finish;
    end

endmodule
